[rtl/affine_2d_inverse_macros.svh]
// Assertion macros for the affine 2D inverse block.
`ifndef AFFINE_2D_INVERSE_MACROS_SVH
`define AFFINE_2D_INVERSE_MACROS_SVH
`ifndef SYNTH
`define A2I_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("a2i check failed");
`define A2I_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("a2i check failed");
`else
`define A2I_ASSERT(lbl, clk, rstn, prop)
`define A2I_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/a2i_pkg.sv]
package a2i_pkg;

    typedef enum logic [1:0] {
        PATH_DIAG = 2'd0,
        PATH_ANTI = 2'd1,
        PATH_GEN  = 2'd2
    } path_t;

    localparam int USER_W = 4;
    localparam int NUM_COEF = 6;

endpackage

[rtl/affine_2d_inverse.sv]
// Inverts a 2D affine transform given as six signed fixed-point coefficients
// (COEF_WIDTH bits, FRAC_BITS fraction bits) and returns the six inverse
// coefficients with the path used, a clip flag and a singular flag. One matrix
// is taken per clock cycle sustained while the output is not stalled. A result
// passes through the front register, the queue, one operand stage,
// COEF_WIDTH + 2 stages of the restoring divider in six lanes (an operand
// load, an overflow check, then one quotient bit per stage), and the output
// register before m_tvalid rises.
// The input side keeps taking transactions while the output waits, until the
// front register and the two-entry queue behind the multiplier stage are full.
module affine_2d_inverse
    import a2i_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int DataW = ((NUM_COEF * COEF_WIDTH + 7) / 8) * 8,
    localparam int RecW  = 18 * COEF_WIDTH + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DataW-1:0]  s_tdata,   // m11, m12, m13, m21, m22, m23
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DataW-1:0]  m_tdata,   // r11, r12, r13, r21, r22, r23
    output logic [USER_W-1:0] m_tuser    // path_taken[1:0], clipped, singular
);

    logic                           push_valid;
    logic                           q_full;
    logic [RecW-1:0]                push_rec;
    logic                           q_pop;
    logic                           q_valid;
    logic [RecW-1:0]                q_rec;
    logic [NUM_COEF*COEF_WIDTH-1:0] r_coef;
    path_t                          r_path;
    logic                           r_clipped;
    logic                           r_singular;

    a2i_front #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_coef    (s_tdata[NUM_COEF*COEF_WIDTH-1:0]),
        .push_valid (push_valid),
        .q_full     (q_full),
        .push_rec   (push_rec)
    );

    a2i_queue #(
        .WIDTH (RecW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rec)
    );

    a2i_back #(
        .COEF_WIDTH (COEF_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_rec        (q_rec),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_coef     (r_coef),
        .out_path     (r_path),
        .out_clipped  (r_clipped),
        .out_singular (r_singular)
    );

    assign m_tdata = DataW'(r_coef);
    assign m_tuser = {r_singular, r_clipped, r_path};

endmodule

[rtl/a2i_front.sv]
module a2i_front
    import a2i_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    localparam int RecW = 18 * COEF_WIDTH + 2
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [NUM_COEF*COEF_WIDTH-1:0]   in_coef,
    output logic                             push_valid,
    input  logic                             q_full,
    output logic [RecW-1:0]                  push_rec
);

    localparam int W = COEF_WIDTH;

    logic                   valid_reg, valid_next;
    logic [RecW-1:0]        rec_reg, rec_next;
    logic signed [W-1:0]    m [NUM_COEF];
    logic signed [2*W-1:0]  p [NUM_COEF];
    path_t                  path;
    logic                   accept;

    always_comb begin
        for (int i = 0; i < NUM_COEF; i++) begin
            m[i] = $signed(in_coef[i*W +: W]);
        end
        p[0] = (2*W)'(m[0]) * (2*W)'(m[4]);
        p[1] = (2*W)'(m[1]) * (2*W)'(m[3]);
        p[2] = (2*W)'(m[1]) * (2*W)'(m[5]);
        p[3] = (2*W)'(m[4]) * (2*W)'(m[2]);
        p[4] = (2*W)'(m[3]) * (2*W)'(m[2]);
        p[5] = (2*W)'(m[0]) * (2*W)'(m[5]);
        if (m[1] == '0 && m[3] == '0) begin
            path = PATH_DIAG;
        end else if (m[0] == '0 && m[4] == '0) begin
            path = PATH_ANTI;
        end else begin
            path = PATH_GEN;
        end
        rec_next = '0;
        for (int i = 0; i < NUM_COEF; i++) begin
            rec_next[i*W +: W] = m[i];
            rec_next[NUM_COEF*W + i*2*W +: 2*W] = p[i];
        end
        rec_next[18*W +: 2] = path;
    end

    assign in_ready   = !valid_reg || !q_full;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_rec   = rec_reg;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (valid_reg && !q_full) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rec_reg <= rec_next;
        end
    end

endmodule

[rtl/a2i_queue.sv]
module a2i_queue
    import a2i_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/a2i_back.sv]
`include "affine_2d_inverse_macros.svh"

module a2i_back
    import a2i_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    localparam int RecW = 18 * COEF_WIDTH + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  logic [RecW-1:0]                q_rec,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [NUM_COEF*COEF_WIDTH-1:0] out_coef,
    output path_t                          out_path,
    output logic                           out_clipped,
    output logic                           out_singular
);

    localparam int W   = COEF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 1;
    localparam int DMW = 2 * W;
    localparam int NMW = (2 * W + F > W + 2 * F) ? 2 * W + F : W + 2 * F;
    localparam int NSW = NMW + 1;
    localparam int CW  = (NMW > 3 * W) ? NMW : 3 * W;

    localparam logic signed [NSW-1:0] One2F   = NSW'(1) << (2 * F);
    localparam logic signed [DW-1:0]  DenFrac = DW'(1) << F;
    localparam logic signed [DW-1:0]  DenOne  = DW'(1);
    localparam logic [W-1:0]          PosMax  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]          SignBit = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0]  rem;
        logic [DMW-1:0] den;
        logic [W-1:0]   quo;
        logic           over;
        logic           qneg;
        logic           nneg;
        logic           nz;
        logic           dz;
    } lane_t;

    typedef struct packed {
        path_t path;
        logic  sing;
    } ctl_t;

    function automatic logic signed [NSW-1:0] tr_num(input logic signed [W-1:0] d,
                                                     input logic signed [W-1:0] t);
        return (d == '0) ? NSW'(t) - (NSW'(t) <<< (W - 1)) : -(NSW'(t) <<< F);
    endfunction

    function automatic logic signed [DW-1:0] tr_den(input logic signed [W-1:0] d);
        return (d == '0) ? DenFrac : DW'(d);
    endfunction

    logic                   adv;
    logic                   s1_valid_reg;
    logic signed [NSW-1:0]  s1_num_reg [NUM_COEF], s1_num_next [NUM_COEF];
    logic signed [DW-1:0]   s1_den_reg [NUM_COEF], s1_den_next [NUM_COEF];
    path_t                  s1_path_reg, s1_path_next;
    lane_t                  dv_reg [W+2][NUM_COEF];
    lane_t                  dv_next [W+2][NUM_COEF];
    ctl_t                   dc_reg [W+2];
    ctl_t                   dc_next0;
    logic [W+1:0]           dvld_reg;
    logic                   out_valid_reg;
    logic [NUM_COEF*W-1:0]  out_coef_reg, out_coef_next;
    path_t                  out_path_reg;
    logic                   out_clip_reg, out_clip_next;
    logic                   out_sing_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;

    always_comb begin
        logic signed [W-1:0]   mc [NUM_COEF];
        logic signed [2*W-1:0] pc [NUM_COEF];
        logic signed [DW-1:0]  det;
        for (int i = 0; i < NUM_COEF; i++) begin
            mc[i] = $signed(q_rec[i*W +: W]);
            pc[i] = $signed(q_rec[NUM_COEF*W + i*2*W +: 2*W]);
            s1_num_next[i] = '0;
            s1_den_next[i] = DenOne;
        end
        s1_path_next = path_t'(q_rec[18*W +: 2]);
        det = DW'(pc[0]) - DW'(pc[1]);
        case (s1_path_next)
            PATH_DIAG: begin
                s1_num_next[0] = One2F;
                s1_den_next[0] = DW'(mc[0]);
                s1_num_next[2] = tr_num(mc[0], mc[2]);
                s1_den_next[2] = tr_den(mc[0]);
                s1_num_next[4] = One2F;
                s1_den_next[4] = DW'(mc[4]);
                s1_num_next[5] = tr_num(mc[4], mc[5]);
                s1_den_next[5] = tr_den(mc[4]);
            end
            PATH_ANTI: begin
                s1_num_next[1] = One2F;
                s1_den_next[1] = DW'(mc[3]);
                s1_num_next[2] = tr_num(mc[3], mc[5]);
                s1_den_next[2] = tr_den(mc[3]);
                s1_num_next[3] = One2F;
                s1_den_next[3] = DW'(mc[1]);
                s1_num_next[5] = tr_num(mc[1], mc[2]);
                s1_den_next[5] = tr_den(mc[1]);
            end
            PATH_GEN: begin
                for (int i = 0; i < NUM_COEF; i++) begin
                    s1_den_next[i] = det;
                end
                s1_num_next[0] = NSW'(mc[4]) <<< (2 * F);
                s1_num_next[1] = -(NSW'(mc[1]) <<< (2 * F));
                s1_num_next[3] = -(NSW'(mc[3]) <<< (2 * F));
                s1_num_next[4] = NSW'(mc[0]) <<< (2 * F);
                s1_num_next[2] = (NSW'(pc[2]) - NSW'(pc[3])) <<< F;
                s1_num_next[5] = (NSW'(pc[4]) - NSW'(pc[5])) <<< F;
            end
            default: begin
                s1_path_next = PATH_GEN;
            end
        endcase
    end

    always_comb begin
        logic [NSW-1:0] nabs;
        logic [DW-1:0]  dabs;
        for (int i = 0; i < NUM_COEF; i++) begin
            nabs = s1_num_reg[i][NSW-1] ? -s1_num_reg[i] : s1_num_reg[i];
            dabs = s1_den_reg[i][DW-1] ? -s1_den_reg[i] : s1_den_reg[i];
            dv_next[0][i].rem  = CW'(nabs[NMW-1:0]);
            dv_next[0][i].den  = dabs[DMW-1:0];
            dv_next[0][i].quo  = '0;
            dv_next[0][i].over = 1'b0;
            dv_next[0][i].nneg = s1_num_reg[i][NSW-1];
            dv_next[0][i].qneg = s1_num_reg[i][NSW-1] ^ s1_den_reg[i][DW-1];
            dv_next[0][i].nz   = s1_num_reg[i] == '0;
            dv_next[0][i].dz   = s1_den_reg[i] == '0;
        end
        dc_next0.path = s1_path_reg;
        dc_next0.sing = (s1_path_reg == PATH_GEN) && (s1_den_reg[0] == '0);
    end

    for (genvar j = 0; j <= W; j++) begin : g_div
        if (j == 0) begin : g_over
            always_comb begin
                for (int i = 0; i < NUM_COEF; i++) begin
                    dv_next[1][i] = dv_reg[0][i];
                    dv_next[1][i].over = dv_reg[0][i].rem >= (CW'(dv_reg[0][i].den) << W);
                end
            end
        end else begin : g_bit
            always_comb begin
                logic [CW-1:0] sh;
                for (int i = 0; i < NUM_COEF; i++) begin
                    sh = CW'(dv_reg[j][i].den) << (W - j);
                    dv_next[j+1][i] = dv_reg[j][i];
                    if (dv_reg[j][i].rem >= sh) begin
                        dv_next[j+1][i].rem = dv_reg[j][i].rem - sh;
                        dv_next[j+1][i].quo[W-j] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        lane_t l;
        logic [W-1:0] r;
        out_clip_next = 1'b0;
        for (int i = 0; i < NUM_COEF; i++) begin
            l = dv_reg[W+1][i];
            if (l.dz) begin
                if (l.nz) begin
                    r = '0;
                end else begin
                    r = l.nneg ? SignBit : PosMax;
                    out_clip_next = 1'b1;
                end
            end else if (l.qneg) begin
                if (l.over || l.quo > SignBit) begin
                    r = SignBit;
                    out_clip_next = 1'b1;
                end else begin
                    r = -l.quo;
                end
            end else if (l.over || l.quo > PosMax) begin
                r = PosMax;
                out_clip_next = 1'b1;
            end else begin
                r = l.quo;
            end
            out_coef_next[i*W +: W] = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            dvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= q_valid;
            dvld_reg      <= {dvld_reg[W:0], s1_valid_reg};
            out_valid_reg <= dvld_reg[W+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_num_reg  <= s1_num_next;
            s1_den_reg  <= s1_den_next;
            s1_path_reg <= s1_path_next;
            dv_reg      <= dv_next;
            dc_reg[0]   <= dc_next0;
            for (int j = 0; j <= W; j++) begin
                dc_reg[j+1] <= dc_reg[j];
            end
            out_coef_reg <= out_coef_next;
            out_path_reg <= dc_reg[W+1].path;
            out_clip_reg <= out_clip_next;
            out_sing_reg <= dc_reg[W+1].sing;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_coef     = out_coef_reg;
    assign out_path     = out_path_reg;
    assign out_clipped  = out_clip_reg;
    assign out_singular = out_sing_reg;

    `A2I_ASSERT(a_sing_gen, aclk, aresetn, out_valid_reg && out_sing_reg |-> out_path_reg == PATH_GEN)
    `A2I_ASSERT(a_diag_zero, aclk, aresetn, out_valid_reg && out_path_reg == PATH_DIAG |-> out_coef_reg[W +: W] == '0 && out_coef_reg[3*W +: W] == '0)
    `A2I_ASSERT(a_anti_zero, aclk, aresetn, out_valid_reg && out_path_reg == PATH_ANTI |-> out_coef_reg[0 +: W] == '0 && out_coef_reg[4*W +: W] == '0)
    `A2I_ASSERT(a_stall_hold, aclk, aresetn, !adv |=> $stable(dvld_reg))

endmodule

[bench/affine_2d_inverse_tb.sv]
`timescale 1ns / 100ps

module affine_2d_inverse_tb;
    import a2i_pkg::*;

    localparam int CW       = 32;
    localparam int FB       = 16;
    localparam int DATA_W   = 192;
    localparam int N_RANDOM = 1580;
    localparam int QUIET_AT = N_RANDOM - 150;

    localparam logic [CW-1:0] POS_CODE = 32'h7fff_ffff;
    localparam logic [CW-1:0] NEG_CODE = 32'h8000_0000;
    localparam logic signed [127:0] POS_W = 128'sd2147483647;
    localparam logic signed [127:0] NEG_W = -128'sd2147483648;
    localparam logic signed [127:0] ONE_W = 128'sd1;

    typedef logic [CW-1:0] coef6_t [6];

    typedef struct {
        coef6_t  r;
        path_t   path;
        bit      clip;
        bit      sing;
    } inverse_t;

    typedef struct {
        coef6_t   m;
        bit       typed;
        inverse_t want;
    } stim_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;

    inverse_t  pending_inverses[$];
    stim_row_t directed_rows[$];
    int        errors;
    int        sent_count;
    int        seen_count;
    int        path_hits[3];
    int        clip_hits;
    int        sing_hits;
    bit        quiet;

    affine_2d_inverse uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // m11, m12, m13, m21, m22, m23
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // r11, r12, r13, r21, r22, r23
        .m_tuser  (m_tuser)    // path_taken[1:0], clipped, singular
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic [CW-1:0] sat_code(logic signed [127:0] x, inout bit clip);
        if (x > POS_W) begin
            clip = 1'b1;
            return POS_CODE;
        end
        if (x < NEG_W) begin
            clip = 1'b1;
            return NEG_CODE;
        end
        return x[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] quot_code(logic signed [127:0] n,
                                                logic signed [127:0] d, inout bit clip);
        if (d == 0) begin
            if (n == 0) return '0;
            clip = 1'b1;
            return (n < 0) ? NEG_CODE : POS_CODE;
        end
        return sat_code(n / d, clip);
    endfunction

    task automatic recip_term(input logic signed [127:0] den, input logic signed [127:0] t,
                              inout bit clip, output logic [CW-1:0] inv,
                              output logic [CW-1:0] tr);
        if (den == 0) begin
            inv  = POS_CODE;
            clip = 1'b1;
            tr   = quot_code(-t * POS_W, ONE_W <<< FB, clip);
        end else begin
            inv = quot_code(ONE_W <<< (2 * FB), den, clip);
            tr  = quot_code((-t) <<< FB, den, clip);
        end
    endtask

    task automatic invert_affine(input coef6_t m, output inverse_t res);
        logic signed [127:0] a11, a12, a13, a21, a22, a23, det;
        bit clip;
        a11 = $signed(m[0]);
        a12 = $signed(m[1]);
        a13 = $signed(m[2]);
        a21 = $signed(m[3]);
        a22 = $signed(m[4]);
        a23 = $signed(m[5]);
        clip = 1'b0;
        foreach (res.r[i]) res.r[i] = '0;
        res.sing = 1'b0;
        if (a12 == 0 && a21 == 0) begin
            res.path = PATH_DIAG;
            recip_term(a11, a13, clip, res.r[0], res.r[2]);
            recip_term(a22, a23, clip, res.r[4], res.r[5]);
        end else if (a11 == 0 && a22 == 0) begin
            res.path = PATH_ANTI;
            recip_term(a21, a23, clip, res.r[1], res.r[2]);
            recip_term(a12, a13, clip, res.r[3], res.r[5]);
        end else begin
            res.path = PATH_GEN;
            det = a11 * a22 - a12 * a21;
            res.sing = (det == 0);
            res.r[0] = quot_code(a22 <<< (2 * FB), det, clip);
            res.r[1] = quot_code((-a12) <<< (2 * FB), det, clip);
            res.r[3] = quot_code((-a21) <<< (2 * FB), det, clip);
            res.r[4] = quot_code(a11 <<< (2 * FB), det, clip);
            res.r[2] = quot_code((a12 * a23 - a22 * a13) <<< FB, det, clip);
            res.r[5] = quot_code((a21 * a13 - a11 * a23) <<< FB, det, clip);
        end
        res.clip = clip;
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return POS_CODE;
            2:       return NEG_CODE;
            3:       return CW'($urandom_range(1, 16)) * (($urandom_range(0, 1) != 0) ? -1 : 1);
            4, 5:    return $urandom;
            default: return CW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic coef6_t rand_matrix();
        coef6_t m;
        int k;
        foreach (m[i]) m[i] = rand_coef();
        case ($urandom_range(0, 5))
            0: begin
                m[1] = '0;
                m[3] = '0;
            end
            1: begin
                m[0] = '0;
                m[4] = '0;
            end
            2: begin
                k    = int'($urandom_range(0, 6)) - 3;
                m[0] = CW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
                m[1] = CW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
                m[3] = m[0] * k;
                m[4] = m[1] * k;
            end
            default: ;
        endcase
        return m;
    endfunction

    function automatic stim_row_t make_row(coef6_t m);
        stim_row_t row;
        row.m     = m;
        row.typed = 1'b0;
        return row;
    endfunction

    function automatic stim_row_t make_typed(coef6_t m, coef6_t r, path_t p, bit c, bit s);
        stim_row_t row;
        row.m         = m;
        row.typed     = 1'b1;
        row.want.r    = r;
        row.want.path = p;
        row.want.clip = c;
        row.want.sing = s;
        return row;
    endfunction

    task automatic add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic build_directed();
        add_row(make_typed('{32'h10000, 0, 0, 0, 32'h10000, 0},
            '{32'h10000, 0, 0, 0, 32'h10000, 0}, PATH_DIAG, 1'b0, 1'b0));
        add_row(make_typed('{0, 0, 0, 0, 0, 0},
            '{POS_CODE, 0, 0, 0, POS_CODE, 0}, PATH_DIAG, 1'b1, 1'b0));
        add_row(make_typed('{0, 32'h10000, 0, 32'h10000, 0, 0},
            '{0, 32'h10000, 0, 32'h10000, 0, 0}, PATH_ANTI, 1'b0, 1'b0));
        add_row(make_typed('{32'h10000, 32'h10000, 0, 32'h10000, 32'h10000, 0},
            '{POS_CODE, NEG_CODE, 0, NEG_CODE, POS_CODE, 0}, PATH_GEN, 1'b1, 1'b1));
        add_row(make_typed('{32'h20000, 0, 32'h30000, 0, 32'hffff_0000, 32'h10000},
            '{32'h8000, 0, 32'hfffe_8000, 0, 32'hffff_0000, 32'h10000}, PATH_DIAG, 1'b0, 1'b0));
        add_row(make_row('{0, 0, POS_CODE, 0, 0, NEG_CODE}));
        add_row(make_row('{0, 0, NEG_CODE, 0, 32'h1, POS_CODE}));
        add_row(make_row('{0, NEG_CODE, POS_CODE, 0, 0, NEG_CODE}));
        add_row(make_row('{0, 32'h1, 32'h5, 0, 0, 0}));
        add_row(make_row('{NEG_CODE, 0, NEG_CODE, 0, POS_CODE, POS_CODE}));
        add_row(make_row('{32'h1, 0, 32'h7, 0, 32'hffff_ffff, 32'h3}));
        add_row(make_row('{POS_CODE, POS_CODE, POS_CODE, POS_CODE, POS_CODE, POS_CODE}));
        add_row(make_row('{NEG_CODE, NEG_CODE, NEG_CODE, NEG_CODE, NEG_CODE, NEG_CODE}));
        add_row(make_row('{POS_CODE, NEG_CODE, 32'h1, NEG_CODE, NEG_CODE, 32'hffff_ffff}));
        add_row(make_row('{32'h1, 32'h1, POS_CODE, 32'h1, 32'h2, NEG_CODE}));
        add_row(make_row('{32'h18000, 32'h4000, 32'h12345, 32'hffff_c000,
                           32'h20000, 32'hfedc_ba98}));
        add_row(make_row('{32'h10000, 32'h20000, 32'h0, 32'h20000, 32'h40000,
                           32'h10000}));
        add_row(make_row('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                           32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}));
    endtask

    task automatic send_matrix(input stim_row_t row, input bit allow_idle);
        inverse_t exp_res;
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.m[5], row.m[4], row.m[3], row.m[2], row.m[1], row.m[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (row.typed) exp_res = row.want;
        else invert_affine(row.m, exp_res);
        pending_inverses.insert(pending_inverses.size(), exp_res);
        path_hits[exp_res.path]++;
        clip_hits += exp_res.clip;
        sing_hits += exp_res.sing;
        sent_count++;
    endtask

    task automatic check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        inverse_t w;
        coef6_t got;
        if (aresetn && m_tvalid && m_tready) begin
            seen_count++;
            if (pending_inverses.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, actual %h",
                         $realtime, m_tdata);
            end else begin
                w = pending_inverses.pop_front();
                foreach (got[i]) got[i] = m_tdata[i*CW +: CW];
                foreach (got[i]) check_field($sformatf("r%0d", i), w.r[i], got[i]);
                check_field("path", CW'(w.path), CW'(m_tuser[1:0]));
                check_field("clipped", CW'(w.clip), CW'(m_tuser[2]));
                check_field("singular", CW'(w.sing), CW'(m_tuser[3]));
            end
        end
    end

    initial begin
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else if (!held && sent_count >= 400) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    end

    initial begin
        int wait_cycles;
        errors     = 0;
        sent_count = 0;
        seen_count = 0;
        clip_hits  = 0;
        sing_hits  = 0;
        quiet      = 1'b0;
        path_hits  = '{0, 0, 0};
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        build_directed();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) send_matrix(directed_rows[i], 1'b1);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == QUIET_AT) quiet = 1'b1;
            send_matrix(make_row(rand_matrix()), !quiet);
        end
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_inverses.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (60) @(posedge aclk);
        $display("Inverted %0d matrices (diag %0d, anti %0d, general %0d), %0d results checked;",
                 sent_count, path_hits[0], path_hits[1], path_hits[2], seen_count);
        $display("%0d clipped and %0d singular cases, one long output stall.",
                 clip_hits, sing_hits);
        if (errors == 0 && pending_inverses.size() == 0) begin
            $display("** affine_2d_inverse: PASSED **");
        end else begin
            $display("** affine_2d_inverse: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** affine_2d_inverse: FAILED **");
        $finish;
    end

endmodule
